// ----- design/occupancy_grid_loader_query_unit_defines.svh -----
// Assertion helpers for the occupancy grid loader query unit.
`ifndef OCCUPANCY_GRID_LOADER_QUERY_UNIT_DEFINES_SVH
`define OCCUPANCY_GRID_LOADER_QUERY_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define OGLQ_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define OGLQ_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/oglq_pkg.sv -----
`timescale 1ns / 1ps

package oglq_pkg;

    // Millimetre coordinate as it arrives on the query ports.
    typedef logic signed [15:0] t_mm;

    // Frame parser phase.
    typedef logic [2:0] t_phase;

    localparam t_phase PH_DATA = 3'd0;
    localparam t_phase PH_DASH = 3'd1;
    localparam t_phase PH_CKHI = 3'd2;
    localparam t_phase PH_CKLO = 3'd3;
    localparam t_phase PH_DONE = 3'd4;

    // Request and result kinds.
    localparam logic OP_CHAR      = 1'b0;
    localparam logic OP_QUERY     = 1'b1;
    localparam logic KIND_QUERY   = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    // Playing field size in millimetres.
    localparam int FIELD_X_MM = 3000;
    localparam int FIELD_Y_MM = 2000;

    // Reciprocal scaling: index = (|mm| * M) >> RECIP_SHIFT, exact for |mm| <= 32768.
    localparam int ABS_W       = 17;
    localparam int RECIP_SHIFT = 28;
    localparam int RECIP_W     = 25;
    localparam int PROD_W      = ABS_W + RECIP_W;
    localparam int QUOT_W      = PROD_W - RECIP_SHIFT;

    // ASCII characters of the frame syntax.
    localparam logic [7:0] CH_DASH = 8'h2D;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_9    = 8'h39;
    localparam logic [7:0] CH_UA   = 8'h41;
    localparam logic [7:0] CH_UF   = 8'h46;
    localparam logic [7:0] CH_LA   = 8'h61;
    localparam logic [7:0] CH_LF   = 8'h66;
    localparam logic [7:0] HEX_TEN = 8'd10;

    function automatic logic hex_ok(input logic [7:0] c);
        return ((c >= CH_0) && (c <= CH_9)) || ((c >= CH_UA) && (c <= CH_UF)) ||
               ((c >= CH_LA) && (c <= CH_LF));
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        v = 8'd0;
        if ((c >= CH_0) && (c <= CH_9)) begin
            v = c - CH_0;
        end else if ((c >= CH_UA) && (c <= CH_UF)) begin
            v = c - CH_UA + HEX_TEN;
        end else if ((c >= CH_LA) && (c <= CH_LF)) begin
            v = c - CH_LA + HEX_TEN;
        end
        return v[3:0];
    endfunction

endpackage

// ----- design/oglq_ram.sv -----
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered data.
module oglq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- design/occupancy_grid_loader_query_unit.sv -----
`timescale 1ns / 1ps

// Occupancy grid loader and query unit. Each request is either one character of a map
// frame (hex pairs for FRAME_BYTES bytes, a dash, two hex checksum digits, the final
// character flagged) or a query of a position in millimetres on a 3000 by 2000 mm field.
// Requests are accepted at one per clock cycle while o_stall is low, and each result
// passes four registers on its way to the outputs: an input register, a parse and
// scaling stage, the map RAM's registered read, and the result register. Only queries
// and frame-ending characters produce a result. Two banks of the map live in one
// byte-wide RAM of 2 * 2^ceil(log2(ceil(CELLS_X * CELLS_Y / 8))) entries; a fill count
// per bank stands in for clearing it, so there is no clearing pass after reset and
// the block is ready on the first cycle.
module occupancy_grid_loader_query_unit #(
    parameter int CELLS_X     = 30,
    parameter int CELLS_Y     = 20,
    parameter int FRAME_BYTES = 75
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    // Request channel
    input  logic           i_valid,
    output logic           o_stall,
    input  logic           i_op,
    input  logic [7:0]     i_frame_char,
    input  logic           i_frame_last,
    input  oglq_pkg::t_mm  i_query_x,
    input  oglq_pkg::t_mm  i_query_y,
    // Result channel
    output logic           o_valid,
    input  logic           i_stall,
    output logic           o_kind,
    output logic           o_occupied,
    output logic           o_frame_ok
);

    import oglq_pkg::*;

    `include "occupancy_grid_loader_query_unit_defines.svh"

    // Geometry. Each RAM byte holds eight consecutive cells in row-major order.
    localparam int NCELLS = CELLS_X * CELLS_Y;
    localparam int NBYTES = (NCELLS + 7) / 8;
    localparam int BA_W   = (NBYTES > 1) ? $clog2(NBYTES) : 1;
    localparam int CW_F   = $clog2(FRAME_BYTES + 1);
    localparam int CW_N   = $clog2(NBYTES + 1);
    localparam int CW     = (CW_F > CW_N) ? CW_F : CW_N;
    localparam int CLW    = BA_W + 3;
    localparam int GXW    = (CELLS_X > 1) ? $clog2(CELLS_X) : 1;
    localparam int GYW    = (CELLS_Y > 1) ? $clog2(CELLS_Y) : 1;
    localparam int RAM_D  = 2 << BA_W;

    localparam logic [CW-1:0]  FB_C    = CW'(FRAME_BYTES);
    localparam logic [CW-1:0]  NB_C    = CW'(NBYTES);
    // Bytes of an accepted map that really came from the frame; the rest read as free.
    localparam logic [CW-1:0]  FILL_OK = (FRAME_BYTES < NBYTES) ? FB_C : NB_C;
    localparam logic [CLW-1:0] CX_C    = CLW'(CELLS_X);
    localparam logic [QUOT_W-1:0] CX_Q = QUOT_W'(CELLS_X);
    localparam logic [QUOT_W-1:0] CY_Q = QUOT_W'(CELLS_Y);

    // Rounded-up reciprocals of 3000 / CELLS_X and 2000 / CELLS_Y, scaled by 2^RECIP_SHIFT.
    localparam logic [RECIP_W-1:0] MX = RECIP_W'(((64'(CELLS_X) << RECIP_SHIFT) +
                                         64'(FIELD_X_MM) - 64'd1) / 64'(FIELD_X_MM));
    localparam logic [RECIP_W-1:0] MY = RECIP_W'(((64'(CELLS_Y) << RECIP_SHIFT) +
                                         64'(FIELD_Y_MM) - 64'd1) / 64'(FIELD_Y_MM));

    // Input register.
    logic            r_p1_v;
    logic            r_p1_op;
    logic [7:0]      r_p1_char;
    logic            r_p1_last;
    t_mm             r_p1_x;
    t_mm             r_p1_y;

    // Stage 2: scaled cell coordinates or frame status.
    logic            r_p2_v;
    logic            r_p2_kind;
    logic            r_p2_ok;
    logic            r_p2_in;
    logic [GXW-1:0]  r_p2_gx;
    logic [GYW-1:0]  r_p2_gy;

    // Stage 3: RAM read in flight.
    logic            r_p3_v;
    logic            r_p3_kind;
    logic            r_p3_ok;
    logic            r_p3_hit;
    logic [2:0]      r_p3_bit;

    // Result register.
    logic            r_o_v;
    logic            r_o_kind;
    logic            r_o_occ;
    logic            r_o_ok;

    // Pipeline flow control. Every stage moves forward when the stage after it is empty
    // or moving, so bubbles close up and a waiting result blocks new requests only once
    // every stage holds a request.
    logic free_o, free1, free2, free3;
    logic mv1, mv2, mv3;

    assign free_o  = !o_valid || !i_stall;
    assign mv3     = r_p3_v && free_o;
    assign free3   = !r_p3_v || free_o;
    assign mv2     = r_p2_v && free3;
    assign free2   = !r_p2_v || free3;
    assign mv1     = r_p1_v && free2;
    assign free1   = !r_p1_v || free2;
    assign o_stall = !free1;

    // Map and parser state. The shadow bank is always the one that is not live, and its
    // fill count is simply the number of data bytes taken so far in the current frame.
    logic            r_live_bank, n_live_bank;
    logic [CW-1:0]   r_live_fill, n_live_fill;
    t_phase          r_phase, n_phase;
    logic [CW-1:0]   r_char_count, n_char_count;
    logic [3:0]      r_high_nibble, n_high_nibble;
    logic [7:0]      r_xor_sum, n_xor_sum;
    logic            r_format_error, n_format_error;
    logic            r_nib_pending, n_nib_pending;
    logic            r_ck_match, n_ck_match;

    // Frame parser. It runs when a character leaves the input register.
    logic            ch_hex;
    logic [3:0]      ch_val;
    logic [7:0]      data_byte;
    logic            frame_ok;
    logic            wr_en;
    logic [BA_W:0]   wr_addr;

    assign ch_hex    = hex_ok(r_p1_char);
    assign ch_val    = hex_val(r_p1_char);
    assign data_byte = {r_high_nibble, ch_val};
    assign wr_addr   = {~r_live_bank, r_char_count[BA_W-1:0]};

    always_comb begin
        n_live_bank    = r_live_bank;
        n_live_fill    = r_live_fill;
        n_phase        = r_phase;
        n_char_count   = r_char_count;
        n_high_nibble  = r_high_nibble;
        n_xor_sum      = r_xor_sum;
        n_format_error = r_format_error;
        n_nib_pending  = r_nib_pending;
        n_ck_match     = r_ck_match;
        frame_ok       = 1'b0;
        wr_en          = 1'b0;
        if (mv1 && (r_p1_op == OP_CHAR)) begin
            case (r_phase)
                PH_DATA: begin
                    if (!ch_hex) begin
                        n_format_error = 1'b1;
                    end else if (!r_nib_pending) begin
                        n_high_nibble = ch_val;
                        n_nib_pending = 1'b1;
                    end else begin
                        // Byte complete: bytes past the end of the grid are dropped.
                        n_nib_pending = 1'b0;
                        n_xor_sum     = r_xor_sum ^ data_byte;
                        wr_en         = (r_char_count < NB_C);
                        n_char_count  = r_char_count + CW'(1);
                        if ((r_char_count + CW'(1)) >= FB_C) begin
                            n_phase = PH_DASH;
                        end
                    end
                end
                PH_DASH: begin
                    if (r_p1_char == CH_DASH) begin
                        n_phase = PH_CKHI;
                    end else begin
                        n_format_error = 1'b1;
                    end
                end
                PH_CKHI: begin
                    if (!ch_hex) begin
                        n_format_error = 1'b1;
                    end else begin
                        n_high_nibble = ch_val;
                        n_phase       = PH_CKLO;
                    end
                end
                PH_CKLO: begin
                    if (!ch_hex) begin
                        n_format_error = 1'b1;
                    end else begin
                        n_ck_match = (data_byte == r_xor_sum);
                        n_phase    = PH_DONE;
                    end
                end
                default: begin
                    // Anything after the checksum spoils the frame.
                    n_format_error = 1'b1;
                end
            endcase
            if (r_p1_last) begin
                frame_ok = !n_format_error && (n_phase == PH_DONE) && n_ck_match;
                if (frame_ok) begin
                    n_live_bank = ~r_live_bank;
                    n_live_fill = FILL_OK;
                end
                // Start over; the new shadow bank reads empty because its fill is zero.
                n_phase        = PH_DATA;
                n_char_count   = '0;
                n_high_nibble  = '0;
                n_xor_sum      = '0;
                n_format_error = 1'b0;
                n_nib_pending  = 1'b0;
                n_ck_match     = 1'b0;
            end
        end
    end

    // Query scaling. Magnitudes are scaled by a reciprocal multiply; truncation toward
    // zero means a small negative coordinate still lands on index zero.
    logic [ABS_W-1:0]  abs_x, abs_y;
    logic [PROD_W-1:0] prod_x, prod_y;
    logic [QUOT_W-1:0] q_x, q_y;
    logic              in_x, in_y;

    assign abs_x  = r_p1_x[15] ? (ABS_W'(0) - {1'b1, r_p1_x}) : {1'b0, r_p1_x};
    assign abs_y  = r_p1_y[15] ? (ABS_W'(0) - {1'b1, r_p1_y}) : {1'b0, r_p1_y};
    assign prod_x = PROD_W'(abs_x) * PROD_W'(MX);
    assign prod_y = PROD_W'(abs_y) * PROD_W'(MY);
    assign q_x    = prod_x[PROD_W-1:RECIP_SHIFT];
    assign q_y    = prod_y[PROD_W-1:RECIP_SHIFT];
    assign in_x   = (!r_p1_x[15] || (q_x == '0)) && (q_x < CX_Q);
    assign in_y   = (!r_p1_y[15] || (q_y == '0)) && (q_y < CY_Q);

    // Cell address. Queries in stage 2 have already passed every earlier frame end and
    // no later one, so the current live bank and fill are the ones they must see.
    logic [CLW-1:0]  cell_idx;
    logic [BA_W-1:0] byte_idx;
    logic            cell_hit;
    logic [BA_W:0]   rd_addr;
    logic [7:0]      rd_data;

    assign cell_idx = CLW'(r_p2_gy) * CX_C + CLW'(r_p2_gx);
    assign byte_idx = cell_idx[CLW-1:3];
    assign cell_hit = r_p2_in && (CW'(byte_idx) < r_live_fill);
    assign rd_addr  = {r_live_bank, byte_idx};

    oglq_ram #(
        .WIDTH (8),
        .DEPTH (RAM_D)
    ) u_map_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (data_byte),
        .i_rd_en   (mv2),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v         <= 1'b0;
            r_p2_v         <= 1'b0;
            r_p3_v         <= 1'b0;
            r_o_v          <= 1'b0;
            r_live_bank    <= 1'b0;
            r_live_fill    <= '0;
            r_phase        <= PH_DATA;
            r_char_count   <= '0;
            r_high_nibble  <= '0;
            r_xor_sum      <= '0;
            r_format_error <= 1'b0;
            r_nib_pending  <= 1'b0;
            r_ck_match     <= 1'b0;
        end else begin
            if (i_valid && free1) begin
                r_p1_v <= 1'b1;
            end else if (mv1) begin
                r_p1_v <= 1'b0;
            end
            // Characters that do not end a frame leave a bubble behind them.
            if (mv1) begin
                r_p2_v <= (r_p1_op == OP_QUERY) || r_p1_last;
            end else if (mv2) begin
                r_p2_v <= 1'b0;
            end
            if (mv2) begin
                r_p3_v <= 1'b1;
            end else if (mv3) begin
                r_p3_v <= 1'b0;
            end
            if (mv3) begin
                r_o_v <= 1'b1;
            end else if (!i_stall) begin
                r_o_v <= 1'b0;
            end
            r_live_bank    <= n_live_bank;
            r_live_fill    <= n_live_fill;
            r_phase        <= n_phase;
            r_char_count   <= n_char_count;
            r_high_nibble  <= n_high_nibble;
            r_xor_sum      <= n_xor_sum;
            r_format_error <= n_format_error;
            r_nib_pending  <= n_nib_pending;
            r_ck_match     <= n_ck_match;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_valid && free1) begin
            r_p1_op   <= i_op;
            r_p1_char <= i_frame_char;
            r_p1_last <= i_frame_last;
            r_p1_x    <= i_query_x;
            r_p1_y    <= i_query_y;
        end
        if (mv1) begin
            r_p2_kind <= (r_p1_op == OP_QUERY) ? KIND_QUERY : KIND_STATUS;
            r_p2_ok   <= frame_ok;
            r_p2_in   <= (r_p1_op == OP_QUERY) && in_x && in_y;
            r_p2_gx   <= q_x[GXW-1:0];
            r_p2_gy   <= q_y[GYW-1:0];
        end
        if (mv2) begin
            r_p3_kind <= r_p2_kind;
            r_p3_ok   <= r_p2_ok;
            r_p3_hit  <= cell_hit;
            r_p3_bit  <= cell_idx[2:0];
        end
        if (mv3) begin
            r_o_kind <= r_p3_kind;
            r_o_occ  <= r_p3_hit && rd_data[r_p3_bit];
            r_o_ok   <= r_p3_ok;
        end
    end

    assign o_valid    = r_o_v;
    assign o_kind     = r_o_kind;
    assign o_occupied = r_o_occ;
    assign o_frame_ok = r_o_ok;

    // An accepted map always carries the same fill; anything else means a bad swap.
    `OGLQ_ASSERT_IMP(a_fill_legal, i_clk, i_rst_n, 1'b1,
        (r_live_fill == '0) || (r_live_fill == FILL_OK), "live fill count out of range")
    // Past the data bytes the byte count must stand at the frame length.
    `OGLQ_ASSERT_IMP(a_count_done, i_clk, i_rst_n, r_phase != PH_DATA,
        r_char_count == FB_C, "parser left data phase early")
    // While taking data the byte count stays below the frame length.
    `OGLQ_ASSERT_IMP(a_count_data, i_clk, i_rst_n, r_phase == PH_DATA,
        r_char_count < FB_C, "data byte count overran frame")
    // The banks swap only when a frame-ending character is parsed.
    `OGLQ_ASSERT_NXT(a_swap_on_end, i_clk, i_rst_n,
        !(mv1 && (r_p1_op == OP_CHAR) && r_p1_last),
        r_live_bank == $past(r_live_bank), "bank swapped without frame end")
    // A frame status never reads the map.
    `OGLQ_ASSERT_IMP(a_status_no_hit, i_clk, i_rst_n,
        r_p3_v && (r_p3_kind == KIND_STATUS), !r_p3_hit, "frame status marked as map hit")

endmodule

// ----- verif/oglq_result_checker.sv -----
`timescale 1ns / 1ps

module oglq_result_checker #(
    parameter int CELLS_X     = 30,
    parameter int CELLS_Y     = 20,
    parameter int FRAME_BYTES = 75
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    input  logic          i_req_stall,
    input  logic          i_op,
    input  logic [7:0]    i_frame_char,
    input  logic          i_frame_last,
    input  oglq_pkg::t_mm i_query_x,
    input  oglq_pkg::t_mm i_query_y,
    input  logic          i_res_valid,
    input  logic          i_res_stall,
    input  logic          i_kind,
    input  logic          i_occupied,
    input  logic          i_frame_ok,
    output int            o_fail_count,
    output int            o_answers_due
);
    import oglq_pkg::*;

    localparam int NCELLS     = CELLS_X * CELLS_Y;
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic kind;
        logic occupied;
        logic frame_ok;
    } t_grid_answer;

    t_grid_answer answers_due[$];

    // Both map banks, the live selector and the frame parser state.
    bit         map_bits [0:1][0:NCELLS-1];
    bit         live_sel;
    t_phase     parse_at;
    int         bytes_done;
    logic [3:0] nib_hold;
    logic [7:0] xor_acc;
    bit         fmt_bad;
    bit         nib_half;
    bit         ck_equal;

    function automatic int digit_value(input logic [7:0] c);
        if ((c >= CH_0) && (c <= CH_9)) return int'(c - CH_0);
        if ((c >= CH_UA) && (c <= CH_UF)) return int'(c - CH_UA) + 10;
        if ((c >= CH_LA) && (c <= CH_LF)) return int'(c - CH_LA) + 10;
        return -1;
    endfunction

    task automatic restart_parser();
        parse_at   = PH_DATA;
        bytes_done = 0;
        nib_hold   = 4'h0;
        xor_acc    = 8'h00;
        fmt_bad    = 1'b0;
        nib_half   = 1'b0;
        ck_equal   = 1'b0;
    endtask

    task automatic absorb_char(input logic [7:0] c);
        int         v;
        int         cell_idx;
        logic [7:0] data_byte;
        v = digit_value(c);
        case (parse_at)
            PH_DATA: begin
                if (v < 0) begin
                    fmt_bad = 1'b1;
                end else if (!nib_half) begin
                    nib_hold = v[3:0];
                    nib_half = 1'b1;
                end else begin
                    data_byte = {nib_hold, v[3:0]};
                    nib_half  = 1'b0;
                    xor_acc   = xor_acc ^ data_byte;
                    for (int b = 0; b < 8; b++) begin
                        cell_idx = bytes_done * 8 + b;
                        if (cell_idx < NCELLS) begin
                            map_bits[!live_sel][cell_idx] = data_byte[b];
                        end
                    end
                    bytes_done++;
                    if (bytes_done >= FRAME_BYTES) begin
                        parse_at = PH_DASH;
                    end
                end
            end
            PH_DASH: begin
                if (c == CH_DASH) parse_at = PH_CKHI;
                else fmt_bad = 1'b1;
            end
            PH_CKHI: begin
                if (v < 0) begin
                    fmt_bad = 1'b1;
                end else begin
                    nib_hold = v[3:0];
                    parse_at = PH_CKLO;
                end
            end
            PH_CKLO: begin
                if (v < 0) begin
                    fmt_bad = 1'b1;
                end else begin
                    ck_equal = ({nib_hold, v[3:0]} == xor_acc);
                    parse_at = PH_DONE;
                end
            end
            default: begin
                fmt_bad = 1'b1;
            end
        endcase
    endtask

    task automatic predict_request(input logic op, input logic [7:0] c, input logic last,
                                   input t_mm x, input t_mm y);
        t_grid_answer ans;
        int           gx;
        int           gy;
        logic         ok;
        if (op == OP_CHAR) begin
            absorb_char(c);
            if (last) begin
                ok = !fmt_bad && (parse_at == PH_DONE) && ck_equal;
                if (ok) live_sel = !live_sel;
                for (int i = 0; i < NCELLS; i++) begin
                    map_bits[!live_sel][i] = 1'b0;
                end
                restart_parser();
                ans.kind     = KIND_STATUS;
                ans.occupied = 1'b0;
                ans.frame_ok = ok;
                answers_due.push_back(ans);
            end
        end else begin
            gx = (int'(x) * CELLS_X) / FIELD_X_MM;
            gy = (int'(y) * CELLS_Y) / FIELD_Y_MM;
            ans.kind     = KIND_QUERY;
            ans.frame_ok = 1'b0;
            ans.occupied = 1'b0;
            if ((gx >= 0) && (gx < CELLS_X) && (gy >= 0) && (gy < CELLS_Y)) begin
                ans.occupied = map_bits[live_sel][gy * CELLS_X + gx];
            end
            answers_due.push_back(ans);
        end
    endtask

    always @(posedge i_clk) begin
        t_grid_answer want;
        if (!i_rst_n) begin
            live_sel = 1'b0;
            for (int i = 0; i < NCELLS; i++) begin
                map_bits[0][i] = 1'b0;
                map_bits[1][i] = 1'b0;
            end
            restart_parser();
        end else begin
            if (i_req_valid && !i_req_stall) begin
                predict_request(i_op, i_frame_char, i_frame_last, i_query_x, i_query_y);
            end
            if (i_res_valid && !i_res_stall) begin
                if (answers_due.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= REPORT_MAX) begin
                        $display("%0t: unexpected result kind %b occupied %b frame_ok %b",
                                 $realtime, i_kind, i_occupied, i_frame_ok);
                    end
                end else begin
                    want = answers_due.pop_front();
                    if ((i_kind !== want.kind) || (i_occupied !== want.occupied) ||
                        (i_frame_ok !== want.frame_ok)) begin
                        o_fail_count++;
                        if (o_fail_count <= REPORT_MAX) begin
                            $display("%0t: exp/got kind %b/%b occupied %b/%b ok %b/%b",
                                     $realtime, want.kind, i_kind, want.occupied, i_occupied,
                                     want.frame_ok, i_frame_ok);
                        end
                    end
                end
            end
        end
        o_answers_due = answers_due.size();
    end

endmodule

// ----- verif/tb_occupancy_grid_loader_query_unit.sv -----
`timescale 1ns / 1ps

module tb_occupancy_grid_loader_query_unit;
    import oglq_pkg::*;

    localparam int CELLS_X     = 30;
    localparam int CELLS_Y     = 20;
    localparam int FRAME_BYTES = 75;

    // Each phase of the run sends about this many requests before the idling changes.
    localparam int PHASE_ITEMS   = 650;
    // The margin after the last expected result easily covers the trip through the pipeline.
    localparam int SETTLE_CYCLES = 32;
    // Cycle limit for the watchdog, far beyond the slowest legal run.
    localparam int CYCLE_LIMIT   = 400000;

    // Ways in which a generated frame can be spoiled. A clean frame must be accepted.
    typedef enum int {
        FLAW_NONE,
        FLAW_CKSUM,
        FLAW_DATA_HEX,
        FLAW_DASH,
        FLAW_CK_HEX,
        FLAW_SHORT,
        FLAW_LONG,
        FLAW_TRAILING,
        FLAW_CUT
    } t_frame_flaw;

    // How the map bytes of a frame are filled.
    typedef enum int {
        FILL_RANDOM,
        FILL_ONES,
        FILL_ZEROS,
        FILL_SPARSE
    } t_fill_style;

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_valid      = 1'b0;
    logic       i_op         = OP_CHAR;
    logic [7:0] i_frame_char = 8'h00;
    logic       i_frame_last = 1'b0;
    t_mm        i_query_x    = '0;
    t_mm        i_query_y    = '0;
    logic       i_stall      = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic       o_kind;
    logic       o_occupied;
    logic       o_frame_ok;

    int fail_count;
    int answers_due;
    int sent_count    = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int cycle_count   = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    occupancy_grid_loader_query_unit #(
        .CELLS_X    (CELLS_X),
        .CELLS_Y    (CELLS_Y),
        .FRAME_BYTES(FRAME_BYTES)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_op        (i_op),
        .i_frame_char(i_frame_char),
        .i_frame_last(i_frame_last),
        .i_query_x   (i_query_x),
        .i_query_y   (i_query_y),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_kind      (o_kind),
        .o_occupied  (o_occupied),
        .o_frame_ok  (o_frame_ok)
    );

    // The checker watches both channels, keeps its own copy of the map and parser, counts
    // every wrong or unexpected result, and reports how many results are still due.
    oglq_result_checker #(
        .CELLS_X    (CELLS_X),
        .CELLS_Y    (CELLS_Y),
        .FRAME_BYTES(FRAME_BYTES)
    ) answer_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_valid),
        .i_req_stall  (o_stall),
        .i_op         (i_op),
        .i_frame_char (i_frame_char),
        .i_frame_last (i_frame_last),
        .i_query_x    (i_query_x),
        .i_query_y    (i_query_y),
        .i_res_valid  (o_valid),
        .i_res_stall  (i_stall),
        .i_kind       (o_kind),
        .i_occupied   (o_occupied),
        .i_frame_ok   (o_frame_ok),
        .o_fail_count (fail_count),
        .o_answers_due(answers_due)
    );

    // The result side stalls at random with the rate of the current phase.
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    // Watchdog: a hung block or a result that never arrives ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_occupancy_grid_loader_query_unit NOT OK");
            $finish;
        end
    end

    // Drives one request and holds it until the block takes it. The sender may idle
    // first; the decision never looks at the stall. Stall is sampled at the falling edge,
    // where it is settled, to learn whether the coming rising edge accepts the request.
    task automatic send_request(input logic op, input logic [7:0] c, input logic last,
                                input t_mm x, input t_mm y);
        logic took;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_op         <= op;
        i_frame_char <= c;
        i_frame_last <= last;
        i_query_x    <= x;
        i_query_y    <= y;
        do begin
            @(negedge i_clk);
            took = !o_stall;
            @(posedge i_clk);
        end while (!took);
        sent_count++;
    endtask

    // Fields that the operation does not use still carry random values, so that every
    // bit of every port toggles.
    task automatic send_char(input logic [7:0] c, input logic last);
        send_request(OP_CHAR, c, last, t_mm'($urandom), t_mm'($urandom));
    endtask

    task automatic send_query(input t_mm x, input t_mm y);
        send_request(OP_QUERY, 8'($urandom), 1'($urandom), x, y);
    endtask

    // A hex digit in upper or lower case, chosen at random.
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10) return CH_0 + 8'(nib);
        return ($urandom_range(1) ? CH_UA : CH_LA) + 8'(nib) - HEX_TEN;
    endfunction

    function automatic logic [7:0] non_hex_char();
        logic [7:0] c;
        do begin
            c = 8'($urandom);
        end while (hex_ok(c));
        return c;
    endfunction

    // A coordinate at one of the interesting values of an axis whose field size is span.
    function automatic t_mm corner_mm(input int span);
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            4: return t_mm'(span);
            5: return t_mm'(span - 1);
            6: return t_mm'(-100);
            default: return t_mm'(-99);
        endcase
    endfunction

    // A coordinate within 150 mm of either border of the axis.
    function automatic t_mm near_border(input int span);
        int base;
        base = $urandom_range(1) ? span : 0;
        return t_mm'(base + int'($urandom_range(300)) - 150);
    endfunction

    // Most queries land inside the field so that they read real map contents; the rest
    // go near the borders, to the corner values, or anywhere in the 16-bit range.
    task automatic send_random_query();
        int  pick;
        t_mm x;
        t_mm y;
        pick = $urandom_range(99);
        if (pick < 60) begin
            x = t_mm'($urandom_range(FIELD_X_MM - 1));
            y = t_mm'($urandom_range(FIELD_Y_MM - 1));
        end else if (pick < 72) begin
            x = near_border(FIELD_X_MM);
            y = near_border(FIELD_Y_MM);
        end else if (pick < 90) begin
            x = t_mm'($urandom);
            y = t_mm'($urandom);
        end else begin
            x = corner_mm(FIELD_X_MM);
            y = corner_mm(FIELD_Y_MM);
        end
        send_query(x, y);
    endtask

    // Builds one map frame as text, spoils it as asked, and sends it with the last
    // character flagged. Queries are sprinkled between the characters now and then,
    // since a query must not disturb the parse.
    task automatic send_frame(input t_frame_flaw flaw);
        logic [7:0]  text[$];
        logic [7:0]  data_val;
        logic [7:0]  ck;
        int          n_bytes;
        int          pos;
        int          keep;
        t_fill_style fill;
        text.delete();
        n_bytes = FRAME_BYTES;
        if (flaw == FLAW_SHORT) n_bytes = $urandom_range(FRAME_BYTES - 1);
        if (flaw == FLAW_LONG) n_bytes = FRAME_BYTES + $urandom_range(3, 1);
        fill = t_fill_style'($urandom_range(3));
        ck   = 8'h00;
        for (int i = 0; i < n_bytes; i++) begin
            case (fill)
                FILL_RANDOM: data_val = 8'($urandom);
                FILL_ONES:   data_val = 8'hFF;
                FILL_ZEROS:  data_val = 8'h00;
                default:     data_val = 8'($urandom & $urandom & $urandom);
            endcase
            ck = ck ^ data_val;
            text.push_back(hex_char(data_val[7:4]));
            text.push_back(hex_char(data_val[3:0]));
        end
        // A short frame sometimes also ends on half a byte.
        if ((flaw == FLAW_SHORT) && ($urandom_range(1) == 1)) begin
            text.push_back(hex_char(4'($urandom)));
        end
        if (flaw == FLAW_CKSUM) ck = ck ^ 8'($urandom_range(255, 1));
        // A missing separator is either dropped or replaced by some other character.
        if (flaw != FLAW_DASH) begin
            text.push_back(CH_DASH);
        end else if ($urandom_range(1) == 1) begin
            do begin
                data_val = 8'($urandom);
            end while (data_val == CH_DASH);
            text.push_back(data_val);
        end
        text.push_back(hex_char(ck[7:4]));
        text.push_back(hex_char(ck[3:0]));
        if ((flaw == FLAW_DATA_HEX) && (n_bytes > 0)) begin
            pos = $urandom_range(2 * n_bytes - 1);
            text[pos] = non_hex_char();
        end
        if (flaw == FLAW_CK_HEX) begin
            pos = text.size() - 1 - $urandom_range(1);
            text[pos] = non_hex_char();
        end
        if (flaw == FLAW_TRAILING) begin
            repeat ($urandom_range(3, 1)) text.push_back(8'($urandom));
        end
        // A cut frame ends anywhere before its checksum is complete.
        if (flaw == FLAW_CUT) begin
            keep = $urandom_range(text.size() - 1, 1);
            while (text.size() > keep) void'(text.pop_back());
        end
        for (int i = 0; i < text.size(); i++) begin
            if ($urandom_range(99) < 3) send_random_query();
            send_char(text[i], i == text.size() - 1);
        end
    endtask

    initial begin
        int pick;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int phase_no = 0; phase_no < 3; phase_no++) begin
            // Sender idles lightly while the receiver stalls hard, then the reverse,
            // then both sides run flat out.
            case (phase_no)
                0: begin
                    send_idle_pct = 20;
                    stall_pct     = 61;
                end
                1: begin
                    send_idle_pct = 61;
                    stall_pct     = 20;
                end
                default: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
            endcase

            if (phase_no == 0) begin
                // Directed opening on the cleared map: queries at the field corners, just
                // past the borders, at small negative values that still truncate to cell
                // zero, and at the extremes of the 16-bit range; all must read free.
                send_query(t_mm'(0), t_mm'(0));
                send_query(t_mm'(FIELD_X_MM - 1), t_mm'(FIELD_Y_MM - 1));
                send_query(t_mm'(FIELD_X_MM), t_mm'(0));
                send_query(t_mm'(0), t_mm'(FIELD_Y_MM));
                send_query(t_mm'(-1), t_mm'(-1));
                send_query(t_mm'(-99), t_mm'(-99));
                send_query(t_mm'(-100), t_mm'(0));
                send_query(t_mm'(0), t_mm'(-100));
                send_query(16'h8000, 16'h8000);
                send_query(16'h7FFF, 16'h7FFF);
                send_query(16'h5555, 16'hAAAA);
                // Frames of one character: a non-hex digit, a lone separator, and a
                // single hex digit. Each ends the frame and must be rejected.
                send_char("G", 1'b1);
                send_char(CH_DASH, 1'b1);
                send_char("a", 1'b1);
                // A frame with a well-formed tail but far too little data.
                send_char("0", 1'b0);
                send_char("0", 1'b0);
                send_char(CH_DASH, 1'b0);
                send_char("0", 1'b0);
                send_char("0", 1'b1);
                // Characters without the last flag produce nothing until a frame ends.
                send_char("F", 1'b0);
                send_char(8'hFF, 1'b1);
                send_query(t_mm'(0), t_mm'(0));
            end

            // Random part: mostly well-formed frames with random contents so that the
            // map really changes, plus spoiled frames and bursts of queries.
            while (sent_count < PHASE_ITEMS * (phase_no + 1)) begin
                pick = $urandom_range(99);
                if (pick < 30) begin
                    send_frame(FLAW_NONE);
                end else if (pick < 65) begin
                    send_frame(t_frame_flaw'($urandom_range(FLAW_CUT, FLAW_CKSUM)));
                end else begin
                    repeat ($urandom_range(24, 4)) send_random_query();
                end
            end
        end

        i_valid <= 1'b0;

        // Wait until every result has come back, then a while longer so that a stray
        // extra result would still be caught.
        while (answers_due != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("tb_occupancy_grid_loader_query_unit OK");
        end else begin
            $display("tb_occupancy_grid_loader_query_unit NOT OK");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+design
design/oglq_pkg.sv
design/oglq_ram.sv
design/occupancy_grid_loader_query_unit.sv
verif/oglq_result_checker.sv
verif/tb_occupancy_grid_loader_query_unit.sv
